/* design/assert_macros.svh */
// assertion helpers shared by the top and parser design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_AT(lbl, clk, rst_n, !(cond), msg)

`endif

/* design/bmptf_pkg.sv */
package bmptf_pkg;

  localparam int WORD_INDEX_W = 19;
  localparam int PIXEL_W      = 24;
  localparam int BYTE_W       = 8;
  localparam int START_ROW_W  = 9;
  localparam int START_COL_W  = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 10;
  localparam int POS_W        = 6;
  localparam int PART_W       = 16;

  localparam int FRAME_WIDTH_DEF  = 640;
  localparam int FRAME_HEIGHT_DEF = 480;
  localparam int MAX_DIM_DEF      = 4096;

  // header byte offsets
  localparam logic [POS_W-1:0] WIDTH_POS   = 6'd18;
  localparam logic [POS_W-1:0] HEIGHT_POS  = 6'd22;
  localparam logic [POS_W-1:0] PIXEL_START = 6'd54;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd1;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_PIXEL  = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic              first_byte;
    logic [BYTE_W-1:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [START_ROW_W-1:0] start_row;
    logic [START_COL_W-1:0] start_col;
  } cfg_t;

  typedef struct packed {
    logic                    hit;
    logic [WORD_INDEX_W-1:0] word_index;
    logic [PIXEL_W-1:0]      pixel_word;
  } res_t;

endpackage

/* design/bmp24_to_framebuffer_writer_top.sv */
// channel | direction | transfer when         | payload
// in_     | input     | in_valid & in_ready   | in_first_byte, in_byte_value
// out_    | output    | out_valid & out_ready | out_word_index, out_pixel_word
// cfg_    | input     | cfg_wr_en             | cfg_index, cfg_wdata
//
// one byte per cycle sustained while the output is not stalled; a byte passes
// the input register and then the result register before its output transfer
// the address path is one constant multiply by the frame width and an add
// reset is synchronous, active low; it clears parse state and both registers
// a stalled output holds its result while the input register still fills;
// the input stalls only when both registers are full

`include "assert_macros.svh"

module bmp24_to_framebuffer_writer_top
  import bmptf_pkg::*;
#(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int MAX_DIM      = MAX_DIM_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_first_byte,
  input  logic [BYTE_W-1:0]       in_byte_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [WORD_INDEX_W-1:0] out_word_index,
  output logic [PIXEL_W-1:0]      out_pixel_word,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  in_item_t in_item, item;
  logic     item_valid;
  logic     advance;
  res_t     res;
  cfg_t     cfg_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [WORD_INDEX_W-1:0] out_index_r;
  logic [PIXEL_W-1:0]      out_pixel_r;

  assign in_item.first_byte = in_first_byte;
  assign in_item.byte_value = in_byte_value;

  // the held byte moves on whenever the result register is free or emptying
  assign advance = item_valid && (!out_valid_r || out_ready);

  bmptf_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bmptf_parser #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .MAX_DIM      (MAX_DIM)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .advance (advance),
    .cfg     (cfg_r),
    .res     (res)
  );

  // placement registers, writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_START_ROW: cfg_r.start_row <= cfg_wdata[START_ROW_W-1:0];
        CFG_START_COL: cfg_r.start_col <= cfg_wdata[START_COL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // result register: loaded on advance, cleared once transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res.hit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.hit) begin
      out_index_r <= res.word_index;
      out_pixel_r <= res.pixel_word;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word_index = out_index_r;
  assign out_pixel_word = out_pixel_r;

  `ASSERT_AT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty output")
  `ASSERT_AT(a_index_in_frame, clk, rst_n,
    out_valid |-> (32'(out_word_index) < 32'(FRAME_WIDTH * FRAME_HEIGHT)),
    "word index outside frame")
  `ASSERT_AT(a_out_hold, clk, rst_n,
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_word_index) && $stable(out_pixel_word)),
    "stalled result changed")

endmodule

/* design/bmptf_in_stage.sv */
module bmptf_in_stage
  import bmptf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     take,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* design/bmptf_parser.sv */
`include "assert_macros.svh"

module bmptf_parser
  import bmptf_pkg::*;
#(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int MAX_DIM      = MAX_DIM_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t item,
  input  logic     advance,
  input  cfg_t     cfg,
  output res_t     res
);

  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int SROW_W = ((DIM_W > START_ROW_W) ? DIM_W : START_ROW_W) + 1;
  localparam int SCOL_W = ((DIM_W > START_COL_W) ? DIM_W : START_COL_W) + 1;
  localparam int AREA_W = $clog2(FRAME_WIDTH * FRAME_HEIGHT);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [31:0] raw);
    logic [DIM_W-1:0] r;
    if (raw[31]) begin
      r = '0;
    end else if (raw > 32'(MAX_DIM - 1)) begin
      r = DIM_W'(MAX_DIM - 1);
    end else begin
      r = raw[DIM_W-1:0];
    end
    return r;
  endfunction

  phase_t             phase_r, phase_nxt, cur_phase;
  logic [POS_W-1:0]   pos_r, pos_nxt, cur_pos;
  logic [31:0]        rw_r, rw_nxt, cur_rw;
  logic [31:0]        rh_r, rh_nxt, cur_rh;
  logic [DIM_W-1:0]   col_r, col_nxt, cur_col;
  logic [DIM_W-1:0]   row_r, row_nxt, cur_row;
  logic [1:0]         bip_r, bip_nxt, cur_bip;
  logic [PART_W-1:0]  part_r, part_nxt, cur_part;
  logic [1:0]         pad_r, pad_nxt, cur_pad;

  logic [DIM_W-1:0]   cw, ch;
  logic [POS_W-1:0]   pos_inc;
  logic [1:0]         hdr_byte;
  logic [DIM_W:0]     col_inc, row_inc;
  phase_t             eor_phase;
  logic [SROW_W-1:0]  srow;
  logic [SCOL_W-1:0]  scol;
  logic [AREA_W-1:0]  addr_full;
  logic               on_screen;

  // a start mark drops all parse state before this byte is used
  always_comb begin
    if (item.first_byte) begin
      cur_phase = PH_HEADER;
      cur_pos   = '0;
      cur_rw    = '0;
      cur_rh    = '0;
      cur_col   = '0;
      cur_row   = '0;
      cur_bip   = '0;
      cur_part  = '0;
      cur_pad   = '0;
    end else begin
      cur_phase = phase_r;
      cur_pos   = pos_r;
      cur_rw    = rw_r;
      cur_rh    = rh_r;
      cur_col   = col_r;
      cur_row   = row_r;
      cur_bip   = bip_r;
      cur_part  = part_r;
      cur_pad   = pad_r;
    end
  end

  // size word capture, little endian
  always_comb begin
    rw_nxt   = cur_rw;
    rh_nxt   = cur_rh;
    hdr_byte = 2'(cur_pos - WIDTH_POS);
    if (cur_phase == PH_HEADER) begin
      if (cur_pos >= WIDTH_POS && cur_pos < HEIGHT_POS) begin
        rw_nxt[8*hdr_byte +: 8] = cur_rw[8*hdr_byte +: 8] | item.byte_value;
      end else if (cur_pos >= HEIGHT_POS && cur_pos < HEIGHT_POS + 6'd4) begin
        rh_nxt[8*hdr_byte +: 8] = cur_rh[8*hdr_byte +: 8] | item.byte_value;
      end
    end
  end

  assign cw        = clamp_dim(rw_nxt);
  assign ch        = clamp_dim(rh_nxt);
  assign pos_inc   = cur_pos + 6'd1;
  assign col_inc   = (DIM_W + 1)'(cur_col) + 1'b1;
  assign row_inc   = (DIM_W + 1)'(cur_row) + 1'b1;
  assign eor_phase = (row_inc >= {1'b0, ch}) ? PH_DONE : PH_PIXEL;

  assign srow      = SROW_W'(cfg.start_row) + SROW_W'(cur_row);
  assign scol      = SCOL_W'(cfg.start_col) + SCOL_W'(cur_col);
  assign on_screen = (32'(srow) < 32'(FRAME_HEIGHT)) && (32'(scol) < 32'(FRAME_WIDTH));
  assign addr_full = AREA_W'(srow) * AREA_W'(FRAME_WIDTH) + AREA_W'(scol);

  always_comb begin
    phase_nxt      = cur_phase;
    pos_nxt        = cur_pos;
    col_nxt        = cur_col;
    row_nxt        = cur_row;
    bip_nxt        = cur_bip;
    part_nxt       = cur_part;
    pad_nxt        = cur_pad;
    res.hit        = 1'b0;
    res.word_index = WORD_INDEX_W'(addr_full);
    res.pixel_word = {cur_part[7:0], cur_part[15:8], item.byte_value};
    unique case (cur_phase)
      PH_HEADER: begin
        pos_nxt = pos_inc;
        if (pos_inc >= PIXEL_START) begin
          phase_nxt = (cw == '0 || ch == '0) ? PH_DONE : PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        if (cur_bip == 2'd0) begin
          part_nxt = {8'd0, item.byte_value};
          bip_nxt  = 2'd1;
        end else if (cur_bip == 2'd1) begin
          part_nxt = {item.byte_value, cur_part[7:0]};
          bip_nxt  = 2'd2;
        end else begin
          bip_nxt  = 2'd0;
          part_nxt = '0;
          res.hit  = on_screen;
          col_nxt  = col_inc[DIM_W-1:0];
          if (col_inc >= {1'b0, cw}) begin
            pad_nxt = cw[1:0];
            if (cw[1:0] != 2'd0) begin
              phase_nxt = PH_PAD;
            end else begin
              col_nxt   = '0;
              row_nxt   = row_inc[DIM_W-1:0];
              phase_nxt = eor_phase;
            end
          end
        end
      end
      PH_PAD: begin
        pad_nxt = cur_pad - 2'd1;
        if (cur_pad == 2'd1) begin
          col_nxt   = '0;
          row_nxt   = row_inc[DIM_W-1:0];
          phase_nxt = eor_phase;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      rw_r    <= '0;
      rh_r    <= '0;
      col_r   <= '0;
      row_r   <= '0;
      bip_r   <= '0;
      part_r  <= '0;
      pad_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      rw_r    <= rw_nxt;
      rh_r    <= rh_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      bip_r   <= bip_nxt;
      part_r  <= part_nxt;
      pad_r   <= pad_nxt;
    end
  end

  `ASSERT_NEVER(a_bip_range, clk, rst_n, bip_r == 2'd3, "byte within triple out of range")
  `ASSERT_AT(a_pad_nonzero, clk, rst_n, (phase_r == PH_PAD) |-> (pad_r != 2'd0), "pad phase with no pad bytes")
  `ASSERT_AT(a_hdr_pos, clk, rst_n, (phase_r == PH_HEADER) |-> (pos_r < PIXEL_START), "header position past pixel start")

endmodule

/* test/bmp_pixel_write_checker.sv */
`timescale 1ns / 1ps

module bmp_pixel_write_checker
  import bmptf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_first_byte,
  input  logic [BYTE_W-1:0]       in_byte_value,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [WORD_INDEX_W-1:0] out_word_index,
  input  logic [PIXEL_W-1:0]      out_pixel_word,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  output int                      error_count,
  output int                      writes_predicted,
  output int                      writes_checked,
  output int                      writes_pending
);

  localparam int REPORT_LIMIT = 10;
  localparam int DIM_MAX      = MAX_DIM_DEF - 1;

  typedef struct packed {
    logic [WORD_INDEX_W-1:0] word_index;
    logic [PIXEL_W-1:0]      pixel_word;
  } fb_write_t;

  fb_write_t pending_pixels[$];

  logic [START_ROW_W-1:0] row_origin;
  logic [START_COL_W-1:0] col_origin;

  phase_t            parse_phase;
  logic [POS_W-1:0]  hdr_count;
  logic [31:0]       width_raw;
  logic [31:0]       height_raw;
  logic [11:0]       col_idx;
  logic [11:0]       row_idx;
  logic [1:0]        triple_idx;
  logic [PART_W-1:0] blue_green;
  logic [1:0]        pad_left;

  int errs;
  int predicted;
  int checked;

  // negative sizes become zero, oversized ones saturate
  function automatic logic [11:0] clamp_dim(input logic [31:0] raw);
    if (raw[31]) return '0;
    if (raw > DIM_MAX) return 12'(DIM_MAX);
    return raw[11:0];
  endfunction

  task automatic clear_parse();
    parse_phase = PH_HEADER;
    hdr_count   = '0;
    width_raw   = '0;
    height_raw  = '0;
    col_idx     = '0;
    row_idx     = '0;
    triple_idx  = '0;
    blue_green  = '0;
    pad_left    = '0;
  endtask

  task automatic finish_row();
    col_idx = '0;
    row_idx = row_idx + 1'b1;
    parse_phase = (row_idx >= clamp_dim(height_raw)) ? PH_DONE : PH_PIXEL;
  endtask

  task automatic parse_bmp_byte(input logic first, input logic [BYTE_W-1:0] b);
    int          srow;
    int          scol;
    logic [11:0] w_eff;
    fb_write_t   wr;
    if (first) clear_parse();
    w_eff = clamp_dim(width_raw);
    case (parse_phase)
      PH_HEADER: begin
        if (hdr_count >= WIDTH_POS && hdr_count < HEIGHT_POS)
          width_raw[8 * (hdr_count - WIDTH_POS) +: 8] = b;
        else if (hdr_count >= HEIGHT_POS && hdr_count < HEIGHT_POS + 4)
          height_raw[8 * (hdr_count - HEIGHT_POS) +: 8] = b;
        hdr_count = hdr_count + 1'b1;
        if (hdr_count >= PIXEL_START) begin
          if (clamp_dim(width_raw) == 0 || clamp_dim(height_raw) == 0)
            parse_phase = PH_DONE;
          else
            parse_phase = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        if (triple_idx == 2'd0) begin
          blue_green = {8'h00, b};
          triple_idx = 2'd1;
        end else if (triple_idx == 2'd1) begin
          blue_green[15:8] = b;
          triple_idx = 2'd2;
        end else begin
          srow = int'(row_origin) + int'(row_idx);
          scol = int'(col_origin) + int'(col_idx);
          if (srow < FRAME_HEIGHT_DEF && scol < FRAME_WIDTH_DEF) begin
            wr.word_index = WORD_INDEX_W'(srow * FRAME_WIDTH_DEF + scol);
            wr.pixel_word = {blue_green[7:0], blue_green[15:8], b};
            pending_pixels.push_back(wr);
            predicted++;
          end
          triple_idx = '0;
          blue_green = '0;
          col_idx = col_idx + 1'b1;
          if (col_idx >= w_eff) begin
            pad_left = w_eff[1:0];
            if (pad_left != 0)
              parse_phase = PH_PAD;
            else
              finish_row();
          end
        end
      end
      PH_PAD: begin
        pad_left = pad_left - 1'b1;
        if (pad_left == 0) finish_row();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    fb_write_t exp_wr;
    if (!rst_n) begin
      row_origin = '0;
      col_origin = '0;
      clear_parse();
      pending_pixels.delete();
      errs      = 0;
      predicted = 0;
      checked   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          if (errs < REPORT_LIMIT)
            $display("%0t: unexpected pixel write, index %0d word %06h",
                     $realtime, out_word_index, out_pixel_word);
          errs++;
        end else begin
          exp_wr = pending_pixels.pop_front();
          if (exp_wr.word_index !== out_word_index || exp_wr.pixel_word !== out_pixel_word) begin
            if (errs < REPORT_LIMIT)
              $display("%0t: pixel write mismatch, expected index %0d word %06h, got index %0d word %06h",
                       $realtime, exp_wr.word_index, exp_wr.pixel_word,
                       out_word_index, out_pixel_word);
            errs++;
          end
          checked++;
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == CFG_START_ROW)
          row_origin = cfg_wdata[START_ROW_W-1:0];
        else if (cfg_index == CFG_START_COL)
          col_origin = cfg_wdata[START_COL_W-1:0];
      end
      if (in_valid && in_ready) parse_bmp_byte(in_first_byte, in_byte_value);
    end
    error_count      <= errs;
    writes_predicted <= predicted;
    writes_checked   <= checked;
    writes_pending   <= pending_pixels.size();
  end

endmodule

/* test/bmp24_to_framebuffer_writer_top_tb.sv */
`timescale 1ns / 1ps

module bmp24_to_framebuffer_writer_top_tb;
  import bmptf_pkg::*;

  // run shape
  localparam int RANDOM_BYTES      = 500;
  localparam int QUIET_BYTES       = 120;
  localparam int RANDOM_WRITES_MIN = 48;
  localparam int LONG_HOLD_CYCLES  = 150;
  localparam int SETTLE_CYCLES     = 4;
  localparam int DRAIN_LIMIT       = 10000;
  localparam int CYCLE_LIMIT       = 500000;
  localparam int DIM_MAX           = MAX_DIM_DEF - 1;

  // pixel fill patterns
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;
  localparam int NO_CUT      = -1;

  // register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_first_byte;
  logic [BYTE_W-1:0]       in_byte_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [WORD_INDEX_W-1:0] out_word_index;
  logic [PIXEL_W-1:0]      out_pixel_word;
  logic                    cfg_wr_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  int error_count;
  int writes_predicted;
  int writes_checked;
  int writes_pending;

  // shared between the sender and the receiver
  logic quiet;
  logic long_hold_req;

  int bytes_sent  = 0;
  int files_sent  = 0;
  int cfg_writes  = 0;
  int cycle_count = 0;

  bmp24_to_framebuffer_writer_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_first_byte  (in_first_byte),
    .in_byte_value  (in_byte_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word_index (out_word_index),
    .out_pixel_word (out_pixel_word),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  bmp_pixel_write_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_first_byte    (in_first_byte),
    .in_byte_value    (in_byte_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word_index   (out_word_index),
    .out_pixel_word   (out_pixel_word),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .error_count      (error_count),
    .writes_predicted (writes_predicted),
    .writes_checked   (writes_checked),
    .writes_pending   (writes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixel writes outstanding",
               cycle_count, writes_pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: short random stalls, plus one long hold-off on request so the
  // pipeline fills and back-pressures the byte stream
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one byte transfer; valid stays up between back-to-back bytes
  task automatic push_byte(input logic fb, input logic [BYTE_W-1:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_first_byte <= fb;
    in_byte_value <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // drop valid, let every expected pixel write drain, then let the pipeline
  // empty of bytes that make no write
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (writes_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_writes++;
  endtask

  // builds one file: random header with the given size words, rows of pixel
  // triples plus padding, trailing junk; optionally cut short
  task automatic send_bmp(input logic [31:0] w_raw, input logic [31:0] h_raw,
                          input int cols, input int rows, input int tail,
                          input int fill, input int cut, input logic marked);
    logic [BYTE_W-1:0] file_q[$];
    logic [BYTE_W-1:0] b;
    int i;
    int n_bytes;
    for (i = 0; i < PIXEL_START; i++) begin
      if (i >= WIDTH_POS && i < HEIGHT_POS)
        b = w_raw[8 * (i - WIDTH_POS) +: 8];
      else if (i >= HEIGHT_POS && i < HEIGHT_POS + 4)
        b = h_raw[8 * (i - HEIGHT_POS) +: 8];
      else
        b = 8'($urandom_range(0, 255));
      file_q.push_back(b);
    end
    for (i = 0; i < rows * (cols * 3 + (cols & 3)); i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom_range(0, 255));
      endcase
      file_q.push_back(b);
    end
    for (i = 0; i < tail; i++) file_q.push_back(8'($urandom_range(0, 255)));
    n_bytes = file_q.size();
    if (cut != NO_CUT && cut < n_bytes) n_bytes = cut;
    for (i = 0; i < n_bytes; i++) push_byte((i == 0) ? marked : 1'b0, file_q[i]);
    files_sent++;
  endtask

  task automatic reconfigure();
    wait_idle();
    case ($urandom_range(0, 3))
      0: begin
        set_reg(CFG_START_ROW, '0);
        set_reg(CFG_START_COL, '0);
      end
      1: begin
        // full data width, so masking and off-screen origins come up too
        set_reg(CFG_START_ROW, CFG_DATA_W'($urandom_range(0, 1023)));
        set_reg(CFG_START_COL, CFG_DATA_W'($urandom_range(0, 1023)));
      end
      default: begin
        set_reg(CFG_START_ROW, CFG_DATA_W'($urandom_range(0, 8)));
        set_reg(CFG_START_COL, CFG_DATA_W'($urandom_range(0, 639)));
      end
    endcase
    if ($urandom_range(0, 7) == 0)
      set_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
              CFG_DATA_W'($urandom_range(0, 1023)));
  endtask

  initial begin : stimulus
    int kind;
    int cols;
    int rows;
    int drain;
    int rnd_bytes0;
    int rnd_writes0;
    logic [31:0] h_raw;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_first_byte = 1'b0;
    in_byte_value = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_START_ROW;
    cfg_wdata     = '0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part, registers at their reset values ----
    // stream straight out of reset with no start mark, trailing junk after it
    send_bmp(32'd2, 32'd2, 2, 2, 3, FILL_RANDOM, NO_CUT, 1'b0);
    // padding of one, three and no bytes, all-zero and all-one pixel bytes
    send_bmp(32'd1, 32'd3, 1, 3, 0, FILL_RANDOM, NO_CUT, 1'b1);
    send_bmp(32'd3, 32'd1, 3, 1, 0, FILL_ZERO, NO_CUT, 1'b1);
    send_bmp(32'd4, 32'd2, 4, 2, 0, FILL_ONES, NO_CUT, 1'b1);
    // restart in the middle of pixel data, then in the middle of the header
    send_bmp(32'd5, 32'd4, 5, 4, 0, FILL_RANDOM, PIXEL_START + 20, 1'b1);
    send_bmp(32'd2, 32'd2, 2, 2, 0, FILL_RANDOM, 20, 1'b1);
    send_bmp(32'd2, 32'd1, 2, 1, 1, FILL_RANDOM, NO_CUT, 1'b1);
    // negative and zero sizes give an empty image; whatever follows is ignored
    send_bmp(32'hFFFF_FFF0, 32'd3, 0, 0, 30, FILL_RANDOM, NO_CUT, 1'b1);
    send_bmp(32'd3, 32'h8000_0000, 0, 0, 20, FILL_RANDOM, NO_CUT, 1'b1);
    send_bmp(32'd0, 32'd5, 0, 0, 10, FILL_RANDOM, NO_CUT, 1'b1);
    send_bmp(32'd5, 32'd0, 0, 0, 10, FILL_RANDOM, NO_CUT, 1'b1);
    // width past the limit saturates: first pixels of a very wide row, cut short
    send_bmp(32'h0001_0000, 32'd1, DIM_MAX, 1, 2, FILL_RANDOM, PIXEL_START + 30, 1'b1);
    // receiver holds off for a long stretch while bytes keep coming
    long_hold_req = 1'b1;
    send_bmp(32'd8, 32'd4, 8, 4, 0, FILL_RANDOM, NO_CUT, 1'b1);

    // oversized height near the bottom edge, rows run off the frame
    wait_idle();
    set_reg(CFG_START_ROW, 10'd470);
    set_reg(CFG_START_COL, 10'd5);
    send_bmp(32'd1, 32'h7FFF_FFFF, 1, 20, 0, FILL_RANDOM, NO_CUT, 1'b1);
    // bottom-right corner: clipped on both axes
    wait_idle();
    set_reg(CFG_START_ROW, 10'd479);
    set_reg(CFG_START_COL, 10'd635);
    send_bmp(32'd8, 32'd2, 8, 2, 0, FILL_RANDOM, NO_CUT, 1'b1);
    // all-ones write data is masked to each register width
    wait_idle();
    set_reg(CFG_START_ROW, 10'h3FF);
    set_reg(CFG_START_COL, 10'h3FF);
    send_bmp(32'd2, 32'd1, 2, 1, 0, FILL_RANDOM, NO_CUT, 1'b1);
    // last column on screen; writes to undecoded indexes must change nothing
    wait_idle();
    set_reg(CFG_START_ROW, 10'd0);
    set_reg(CFG_START_COL, 10'd639);
    set_reg(CFG_UNUSED_A, 10'h155);
    set_reg(CFG_UNUSED_B, 10'h2AA);
    send_bmp(32'd3, 32'd2, 3, 2, 0, FILL_RANDOM, NO_CUT, 1'b1);
    wait_idle();
    set_reg(CFG_START_ROW, 10'd0);
    set_reg(CFG_START_COL, 10'd0);

    // ---- random part: mostly well-formed small files, some broken or noisy ----
    rnd_bytes0  = bytes_sent;
    rnd_writes0 = writes_predicted;
    while (bytes_sent - rnd_bytes0 < RANDOM_BYTES ||
           writes_predicted - rnd_writes0 < RANDOM_WRITES_MIN) begin
      // the tail of the run goes at full rate on both sides
      if (bytes_sent - rnd_bytes0 >= RANDOM_BYTES - QUIET_BYTES) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) reconfigure();
      kind = $urandom_range(0, 9);
      cols = $urandom_range(1, 9);
      rows = $urandom_range(1, 4);
      if (kind <= 6) begin
        send_bmp(cols, rows, cols, rows,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0,
                 FILL_RANDOM, NO_CUT, 1'b1);
      end else if (kind == 7) begin
        // cut anywhere, next file restarts the parse
        send_bmp(cols, rows, cols, rows, 0, FILL_RANDOM,
                 $urandom_range(1, PIXEL_START + rows * (cols * 3 + (cols & 3))), 1'b1);
      end else if (kind == 8) begin
        case ($urandom_range(0, 2))
          0: send_bmp({1'b1, 31'($urandom)}, rows, 0, 0, $urandom_range(1, 12),
                      FILL_RANDOM, NO_CUT, 1'b1);
          1: send_bmp($urandom_range(MAX_DIM_DEF, 32'h7FFF_FFFF), 32'd1, DIM_MAX, 1, 0,
                      FILL_RANDOM, PIXEL_START + $urandom_range(1, 60), 1'b1);
          default: begin
            h_raw = $urandom_range(0, 1) ? {1'b1, 31'($urandom)}
                                         : $urandom_range(MAX_DIM_DEF, 32'h7FFF_FFFF);
            send_bmp(cols, h_raw, cols, 2, 0, FILL_RANDOM, NO_CUT, 1'b1);
          end
        endcase
      end else begin
        // loose bytes, some of them start marks
        repeat ($urandom_range(1, 6))
          push_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end

    // ---- drain and verdict ----
    @(negedge clk);
    in_valid <= 1'b0;
    drain = 0;
    while (writes_pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (writes_pending != 0)
      $display("%0d expected pixel writes never arrived", writes_pending);
    $display("sent %0d bytes in %0d files with %0d register writes; %0d pixel writes checked",
             bytes_sent, files_sent, cfg_writes, writes_checked);
    $display("covered unmarked start, restarts, clamped and empty sizes, clipping, long stall");
    if (error_count == 0 && writes_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
